// ----- hdl/two_way_cache_lrf_fill_macros.svh -----
// Assertion macros used by the cache top level.
`ifndef TWO_WAY_CACHE_LRF_FILL_MACROS_SVH
`define TWO_WAY_CACHE_LRF_FILL_MACROS_SVH

`ifndef SYNTHESIS
`define TCL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TCL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCL_ASSERT(lbl, clk, rst_n, prop, msg)
`define TCL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- hdl/tcl_pkg.sv -----
// Types, constants and codes of the two-way least-recently-filled cache.
package tcl_pkg;

  localparam int SETS_DEF  = 128;
  localparam int ADDR_W    = 32;
  localparam int IDX_SHIFT = 6;
  localparam int TAG_LSB   = 13;
  localparam int TAG_W     = 19;
  localparam int WORD_W    = 32;
  localparam int FILL_W    = 64;
  localparam int X_W       = ADDR_W - IDX_SHIFT;
  localparam int M_W       = X_W + 2;

  typedef enum logic [1:0] {
    OP_READ = 2'd0,
    OP_HIT  = 2'd1,
    OP_FILL = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_MUL,
    ST_REM,
    ST_LOOK,
    ST_UPD
  } state_t;

  typedef struct packed {
    logic              valid;
    logic              fill;
    logic [TAG_W-1:0]  tag;
    logic [WORD_W-1:0] word;
  } way_t;

  typedef way_t [1:0] row_t;

  typedef struct packed {
    logic busy;
    logic clr;
    logic ld;
    logic mul;
    logic rem;
    logic look;
    logic upd;
  } ctrl_t;

endpackage

// ----- hdl/two_way_cache_lrf_fill.sv -----
// Top level of the two-way set-associative cache with least-recently-filled fill.
//
//   channel  ports                                          handshake
//   input    in_opcode in_address in_way_select in_fill_data  start high, busy low
//   result   out_read_data out_hit                           out_valid, one cycle
//
// An accepted item keeps busy high through the states MUL and REM of the
// reciprocal multiply that forms the set index, LOOK (RAM read) and UPD (update).
// The result strobe follows the update cycle and overlaps the next accept.
// After reset a clearing pass writes every set with busy high.
// The receiver cannot stall; each result is shown for exactly one cycle.
`include "two_way_cache_lrf_fill_macros.svh"

module two_way_cache_lrf_fill #(
  parameter int SETS = tcl_pkg::SETS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_opcode,
  input  logic [tcl_pkg::ADDR_W-1:0]    in_address,
  input  logic                          in_way_select,
  input  logic [tcl_pkg::FILL_W-1:0]    in_fill_data,
  output logic                          out_valid,
  output logic [tcl_pkg::WORD_W-1:0]    out_read_data,
  output logic                          out_hit
);

  localparam int IDX_W = $clog2(SETS);
  localparam int ROW_W = $bits(tcl_pkg::row_t);

  tcl_pkg::ctrl_t              ctl;
  logic [IDX_W-1:0]            clr_addr;
  logic [IDX_W-1:0]            idx;
  tcl_pkg::op_t                op_r;
  logic [tcl_pkg::TAG_W-1:0]   tag_r;
  logic                        sel_r;
  logic [tcl_pkg::FILL_W-1:0]  data_r;
  tcl_pkg::row_t               row;
  tcl_pkg::row_t               row_new;
  logic                        fill_we;
  logic [tcl_pkg::WORD_W-1:0]  read_data;
  logic                        hit;
  logic                        ram_we;
  logic [IDX_W-1:0]            ram_waddr;
  logic [ROW_W-1:0]            ram_wdata;
  logic [ROW_W-1:0]            ram_rdata;
  logic                        out_valid_r;
  logic [tcl_pkg::WORD_W-1:0]  out_read_data_r;
  logic                        out_hit_r;

  tcl_ctrl #(.SETS(SETS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .ctl      (ctl),
    .clr_addr (clr_addr)
  );

  tcl_index #(.SETS(SETS)) u_index (
    .clk     (clk),
    .ctl     (ctl),
    .addr_hi (in_address[tcl_pkg::ADDR_W-1:tcl_pkg::IDX_SHIFT]),
    .idx     (idx)
  );

  // hold the item while the index and the row are fetched
  always_ff @(posedge clk) begin
    if (ctl.ld) begin
      op_r   <= tcl_pkg::op_t'(in_opcode);
      tag_r  <= in_address[tcl_pkg::ADDR_W-1:tcl_pkg::TAG_LSB];
      sel_r  <= in_way_select;
      data_r <= in_fill_data;
    end
  end

  // clearing pass writes zero rows; otherwise write back a filled row
  assign ram_we    = ctl.clr || (ctl.upd && fill_we);
  assign ram_waddr = ctl.clr ? clr_addr : idx;
  assign ram_wdata = ctl.clr ? '0 : ROW_W'(row_new);

  tcl_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ctl.look),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  assign row = tcl_pkg::row_t'(ram_rdata);

  tcl_exec u_exec (
    .row       (row),
    .op        (op_r),
    .tag       (tag_r),
    .sel       (sel_r),
    .fill_data (data_r),
    .row_new   (row_new),
    .we        (fill_we),
    .read_data (read_data),
    .hit       (hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.upd;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      out_read_data_r <= read_data;
      out_hit_r       <= hit;
    end
  end

  assign busy          = ctl.busy;
  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_hit       = out_hit_r;

  `TCL_ASSERT(a_accept_busy, clk, rst_n, start && !busy |=> busy, "accepted item did not raise busy")
  `TCL_ASSERT(a_one_strobe, clk, rst_n, out_valid |=> !out_valid, "result strobe longer than one cycle")
  `TCL_ASSERT(a_clr_blocks, clk, rst_n, ctl.clr |-> busy && !out_valid, "item taken during clearing pass")
  `TCL_ASSERT(a_fill_zero, clk, rst_n, ctl.upd && op_r == tcl_pkg::OP_FILL |=> out_valid && !out_hit && out_read_data == '0, "fill returned nonzero result")
  `TCL_ASSERT(a_miss_zero, clk, rst_n, out_valid && !out_hit |-> out_read_data == '0, "miss returned nonzero data")

endmodule

// ----- hdl/tcl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/tcl_index.sv -----
// Set index unit: (address >> 6) mod SETS by reciprocal multiply, then remainder.
module tcl_index #(
  parameter int SETS = tcl_pkg::SETS_DEF
) (
  input  logic                      clk,
  input  tcl_pkg::ctrl_t            ctl,
  input  logic [tcl_pkg::X_W-1:0]   addr_hi,
  output logic [$clog2(SETS)-1:0]   idx
);

  localparam int IDX_W  = $clog2(SETS);
  localparam int X_W    = tcl_pkg::X_W;
  localparam int M_W    = tcl_pkg::M_W;
  localparam int PROD_W = X_W + M_W;
  localparam int K      = X_W + IDX_W;
  localparam logic [63:0] M_FULL = ((64'd1 << K) + 64'(SETS - 1)) / 64'(SETS);
  localparam logic [M_W-1:0] MULT = M_W'(M_FULL);
  localparam logic [X_W-1:0] DIV  = X_W'(SETS);

  logic [X_W-1:0]    x_r;
  logic [PROD_W-1:0] prod_r;
  logic [IDX_W-1:0]  idx_r;
  logic [X_W-1:0]    quot;

  // quotient is exact for every 26-bit value with this multiplier and shift
  assign quot = X_W'(prod_r >> K);

  always_ff @(posedge clk) begin
    if (ctl.ld) begin
      x_r <= addr_hi;
    end
    if (ctl.mul) begin
      prod_r <= PROD_W'(x_r) * PROD_W'(MULT);
    end
    if (ctl.rem) begin
      // remainder fits IDX_W bits, so only the low bits are needed
      idx_r <= x_r[IDX_W-1:0] - IDX_W'(quot * DIV);
    end
  end

  assign idx = idx_r;

endmodule

// ----- hdl/tcl_exec.sv -----
// Row update: lookup, hit check and least-recently-filled fill of one set.
module tcl_exec (
  input  tcl_pkg::row_t                 row,
  input  tcl_pkg::op_t                  op,
  input  logic [tcl_pkg::TAG_W-1:0]     tag,
  input  logic                          sel,
  input  logic [tcl_pkg::FILL_W-1:0]    fill_data,
  output tcl_pkg::row_t                 row_new,
  output logic                          we,
  output logic [tcl_pkg::WORD_W-1:0]    read_data,
  output logic                          hit
);

  logic                       m0;
  logic                       m1;
  logic                       w;
  logic [tcl_pkg::WORD_W-1:0] lo;
  logic [tcl_pkg::WORD_W-1:0] hi;

  assign m0 = row[0].valid && (row[0].tag == tag);
  assign m1 = row[1].valid && (row[1].tag == tag);
  assign lo = fill_data[tcl_pkg::WORD_W-1:0];
  assign hi = fill_data[tcl_pkg::FILL_W-1:tcl_pkg::WORD_W];

  // invalid way first, otherwise XOR of the fill bits
  assign w = !row[0].valid ? 1'b0 :
             !row[1].valid ? 1'b1 : (row[0].fill ^ row[1].fill);

  always_comb begin
    row_new   = row;
    we        = 1'b0;
    read_data = '0;
    hit       = 1'b0;
    unique case (op)
      tcl_pkg::OP_READ: begin
        if (m0) begin
          read_data = row[0].word;
          hit       = 1'b1;
        end else if (m1) begin
          read_data = row[1].word;
          hit       = 1'b1;
        end
      end
      tcl_pkg::OP_HIT: begin
        hit = sel ? m1 : m0;
      end
      tcl_pkg::OP_FILL: begin
        we               = 1'b1;
        row_new[w].fill  = ~row[w].fill;
        row_new[w].tag   = tag;
        row_new[w].valid = 1'b1;
        // word placement follows the updated fill bits
        if (row_new[0].fill && !row_new[1].fill) begin
          row_new[0].word = lo;
        end else if (!row_new[0].fill && row_new[1].fill) begin
          row_new[1].word = lo;
        end else begin
          row_new[0].word = lo;
          row_new[1].word = hi;
        end
      end
      tcl_pkg::OP_NOP: begin
      end
    endcase
  end

endmodule

// ----- hdl/tcl_ctrl.sv -----
// Sequencer: clearing pass after reset, then index, read and update steps per item.
module tcl_ctrl #(
  parameter int SETS = tcl_pkg::SETS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output tcl_pkg::ctrl_t          ctl,
  output logic [$clog2(SETS)-1:0] clr_addr
);

  localparam int IDX_W = $clog2(SETS);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(SETS - 1);

  tcl_pkg::state_t  state_r;
  tcl_pkg::state_t  state_nxt;
  logic [IDX_W-1:0] clr_cnt_r;
  logic [IDX_W-1:0] clr_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tcl_pkg::ST_CLR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      tcl_pkg::ST_CLR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST) begin
          state_nxt = tcl_pkg::ST_IDLE;
        end
      end
      tcl_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = tcl_pkg::ST_MUL;
        end
      end
      tcl_pkg::ST_MUL:  state_nxt = tcl_pkg::ST_REM;
      tcl_pkg::ST_REM:  state_nxt = tcl_pkg::ST_LOOK;
      tcl_pkg::ST_LOOK: state_nxt = tcl_pkg::ST_UPD;
      tcl_pkg::ST_UPD:  state_nxt = tcl_pkg::ST_IDLE;
      default:          state_nxt = tcl_pkg::ST_CLR;
    endcase
  end

  always_comb begin
    ctl      = '0;
    ctl.busy = (state_r != tcl_pkg::ST_IDLE);
    ctl.clr  = (state_r == tcl_pkg::ST_CLR);
    ctl.ld   = (state_r == tcl_pkg::ST_IDLE) && start;
    ctl.mul  = (state_r == tcl_pkg::ST_MUL);
    ctl.rem  = (state_r == tcl_pkg::ST_REM);
    ctl.look = (state_r == tcl_pkg::ST_LOOK);
    ctl.upd  = (state_r == tcl_pkg::ST_UPD);
  end

  assign clr_addr = clr_cnt_r;

endmodule

// ----- test/two_way_cache_lrf_fill_check.sv -----
// Checker for the two-way cache: predicts each item's result and compares it.
module two_way_cache_lrf_fill_check
  import tcl_pkg::*;
#(
  parameter int SETS = SETS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        in_opcode,
  input  logic [ADDR_W-1:0] in_address,
  input  logic              in_way_select,
  input  logic [FILL_W-1:0] in_fill_data,
  input  logic              out_valid,
  input  logic [WORD_W-1:0] out_read_data,
  input  logic              out_hit,
  output int                fail_count,
  output int                pending,
  output int                result_count,
  output int                hit_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic              hit;
  } cache_result_t;

  logic [TAG_W-1:0]  tag_store   [SETS][2];
  logic              valid_store [SETS][2];
  logic              fill_store  [SETS][2];
  logic [WORD_W-1:0] word_store  [SETS][2];

  cache_result_t expected_results[$];
  cache_result_t oldest;

  initial begin
    fail_count   = 0;
    pending      = 0;
    result_count = 0;
    hit_count    = 0;
  end

  function automatic logic way_match(int unsigned set_idx, int unsigned way,
                                     logic [TAG_W-1:0] tag);
    return valid_store[set_idx][way] && (tag_store[set_idx][way] == tag);
  endfunction

  // Apply one item to the shadow store and return what the block should answer.
  function automatic cache_result_t cache_access(op_t op, logic [ADDR_W-1:0] addr,
                                                 logic sel, logic [FILL_W-1:0] data);
    int unsigned      set_idx;
    int unsigned      way;
    logic [TAG_W-1:0] tag;
    cache_result_t    res;
    set_idx = (addr >> IDX_SHIFT) % SETS;
    tag     = addr[ADDR_W-1:TAG_LSB];
    res     = '0;
    case (op)
      OP_READ: begin
        if (way_match(set_idx, 0, tag)) begin
          res.read_data = word_store[set_idx][0];
          res.hit       = 1'b1;
        end else if (way_match(set_idx, 1, tag)) begin
          res.read_data = word_store[set_idx][1];
          res.hit       = 1'b1;
        end
      end
      OP_HIT: begin
        res.hit = way_match(set_idx, sel, tag);
      end
      OP_FILL: begin
        // invalid ways first, then the XOR of the two fill bits
        if (!valid_store[set_idx][0]) way = 0;
        else if (!valid_store[set_idx][1]) way = 1;
        else way = fill_store[set_idx][0] ^ fill_store[set_idx][1];
        fill_store[set_idx][way]  = ~fill_store[set_idx][way];
        tag_store[set_idx][way]   = tag;
        valid_store[set_idx][way] = 1'b1;
        // data placement follows the updated fill bits
        if (fill_store[set_idx][0] && !fill_store[set_idx][1]) begin
          word_store[set_idx][0] = data[31:0];
        end else if (!fill_store[set_idx][0] && fill_store[set_idx][1]) begin
          word_store[set_idx][1] = data[31:0];
        end else begin
          word_store[set_idx][0] = data[31:0];
          word_store[set_idx][1] = data[63:32];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SETS; s++) begin
        for (int w = 0; w < 2; w++) begin
          tag_store[s][w]   = '0;
          valid_store[s][w] = 1'b0;
          fill_store[s][w]  = 1'b0;
          word_store[s][w]  = '0;
        end
      end
      expected_results.delete();
    end else begin
      if (start && !busy) begin
        expected_results.push_back(cache_access(op_t'(in_opcode), in_address,
                                                in_way_select, in_fill_data));
      end
      if (out_valid) begin
        result_count++;
        if (out_hit) hit_count++;
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t unexpected result: expected none, actual read_data %h hit %b",
                   $time, out_read_data, out_hit);
        end else begin
          oldest = expected_results.pop_front();
          if (out_read_data !== oldest.read_data) begin
            fail_count++;
            $display("%0t read_data mismatch: expected %h actual %h",
                     $time, oldest.read_data, out_read_data);
          end
          if (out_hit !== oldest.hit) begin
            fail_count++;
            $display("%0t hit mismatch: expected %b actual %b",
                     $time, oldest.hit, out_hit);
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

// ----- test/two_way_cache_lrf_fill_tb.sv -----
// Top of the cache testbench: clock, reset, stimulus and verdict.
module two_way_cache_lrf_fill_tb
  import tcl_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETS         = SETS_DEF;
  localparam int RANDOM_ITEMS = 1100;
  localparam int SET_SLOTS    = 4;
  localparam int TAG_SLOTS    = 3;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_opcode;
  logic [ADDR_W-1:0] in_address;
  logic              in_way_select;
  logic [FILL_W-1:0] in_fill_data;
  logic              out_valid;
  logic [WORD_W-1:0] out_read_data;
  logic              out_hit;

  int fail_count;
  int pending;
  int result_count;
  int hit_count;

  int          idle_pct;
  int          op_count [4];
  logic [6:0]  set_pool [SET_SLOTS];
  logic [18:0] tag_pool [TAG_SLOTS];

  two_way_cache_lrf_fill #(.SETS(SETS)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_opcode     (in_opcode),
    .in_address    (in_address),
    .in_way_select (in_way_select),
    .in_fill_data  (in_fill_data),
    .out_valid     (out_valid),
    .out_read_data (out_read_data),
    .out_hit       (out_hit)
  );

  two_way_cache_lrf_fill_check #(.SETS(SETS)) u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_opcode     (in_opcode),
    .in_address    (in_address),
    .in_way_select (in_way_select),
    .in_fill_data  (in_fill_data),
    .out_valid     (out_valid),
    .out_read_data (out_read_data),
    .out_hit       (out_hit),
    .fail_count    (fail_count),
    .pending       (pending),
    .result_count  (result_count),
    .hit_count     (hit_count)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [ADDR_W-1:0] make_address(logic [18:0] tag, logic [6:0] set_idx,
                                                     logic [5:0] offset);
    return {tag, set_idx, offset};
  endfunction

  // Present one item after a random gap and hold it until it is accepted.
  task automatic issue_access(op_t op, logic [ADDR_W-1:0] addr, logic sel,
                              logic [FILL_W-1:0] data);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start         <= 1'b0;
      in_opcode     <= 2'($urandom_range(3));
      in_address    <= $urandom;
      in_way_select <= 1'($urandom_range(1));
      in_fill_data  <= {$urandom, $urandom};
    end
    @(negedge clk);
    start         <= 1'b1;
    in_opcode     <= op;
    in_address    <= addr;
    in_way_select <= sel;
    in_fill_data  <= data;
    do @(posedge clk); while (busy);
    op_count[op]++;
  endtask

  task automatic refresh_pools();
    for (int i = 0; i < SET_SLOTS; i++) set_pool[i] = 7'($urandom);
    for (int i = 0; i < TAG_SLOTS; i++) tag_pool[i] = 19'($urandom);
  endtask

  task automatic random_access();
    op_t         op;
    int unsigned pick;
    logic [ADDR_W-1:0] addr;
    pick = $urandom_range(99);
    if (pick < 30) op = OP_FILL;
    else if (pick < 62) op = OP_READ;
    else if (pick < 90) op = OP_HIT;
    else op = OP_NOP;
    // mostly a small pool of sets and tags so fills collide and reads hit
    if ($urandom_range(99) < 85) begin
      addr = make_address(tag_pool[$urandom_range(TAG_SLOTS-1)],
                          set_pool[$urandom_range(SET_SLOTS-1)], 6'($urandom));
    end else begin
      addr = $urandom;
    end
    issue_access(op, addr, 1'($urandom_range(1)), {$urandom, $urandom});
  endtask

  task automatic directed_accesses();
    logic [18:0] tag_a;
    logic [18:0] tag_b;
    logic [18:0] tag_c;
    logic [6:0]  set_d;
    tag_a = 19'h00001;
    tag_b = 19'h7FFFF;
    tag_c = 19'h2AAAA;
    set_d = 7'd5;
    // empty set: miss on read and on hit check
    issue_access(OP_READ, make_address(tag_a, set_d, 6'h00), 1'b0, '0);
    issue_access(OP_HIT,  make_address(tag_a, set_d, 6'h3F), 1'b0, '0);
    // first fill takes way 0, second takes way 1
    issue_access(OP_FILL, make_address(tag_a, set_d, 6'h00), 1'b0, 64'h1111_2222_3333_4444);
    issue_access(OP_READ, make_address(tag_a, set_d, 6'h15), 1'b0, '0);
    issue_access(OP_FILL, make_address(tag_b, set_d, 6'h2A), 1'b1, 64'h5555_6666_7777_8888);
    issue_access(OP_READ, make_address(tag_a, set_d, 6'h00), 1'b0, '0);
    issue_access(OP_READ, make_address(tag_b, set_d, 6'h00), 1'b0, '0);
    issue_access(OP_HIT,  make_address(tag_b, set_d, 6'h00), 1'b0, '0);
    issue_access(OP_HIT,  make_address(tag_b, set_d, 6'h00), 1'b1, '0);
    issue_access(OP_HIT,  make_address(tag_a, set_d, 6'h00), 1'b0, '0);
    // full set: replacement follows the fill bits
    issue_access(OP_FILL, make_address(tag_c, set_d, 6'h00), 1'b0, 64'h9999_AAAA_BBBB_CCCC);
    issue_access(OP_READ, make_address(tag_c, set_d, 6'h00), 1'b0, '0);
    issue_access(OP_READ, make_address(tag_a, set_d, 6'h00), 1'b0, '0);
    // refill a tag that is already present
    issue_access(OP_FILL, make_address(tag_c, set_d, 6'h00), 1'b1, 64'hDDDD_EEEE_FFFF_0000);
    issue_access(OP_READ, make_address(tag_c, set_d, 6'h00), 1'b0, '0);
    issue_access(OP_HIT,  make_address(tag_c, set_d, 6'h00), 1'b1, '0);
    // unused opcode leaves the store alone
    issue_access(OP_NOP,  '1, 1'b1, '1);
    issue_access(OP_READ, make_address(tag_c, set_d, 6'h00), 1'b0, '0);
    // all-ones and all-zero extremes
    issue_access(OP_READ, '1, 1'b1, '1);
    issue_access(OP_FILL, '1, 1'b1, '1);
    issue_access(OP_READ, '1, 1'b0, '0);
    issue_access(OP_HIT,  '1, 1'b1, '0);
    issue_access(OP_HIT,  '0, 1'b0, '0);
    issue_access(OP_FILL, '0, 1'b0, '0);
    issue_access(OP_READ, '0, 1'b0, '1);
  endtask

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_opcode     = OP_READ;
    in_address    = '0;
    in_way_select = 1'b0;
    in_fill_data  = '0;
    idle_pct      = 10;
    foreach (op_count[i]) op_count[i] = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed_accesses();
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: idle_pct = 10;
        1: idle_pct = 63;
        default: idle_pct = 0;
      endcase
      refresh_pools();
      for (int i = 0; i < RANDOM_ITEMS / 3; i++) random_access();
    end
    @(negedge clk);
    start <= 1'b0;

    // drain outstanding results, then allow the pipeline to settle
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);

    $display("covered %0d reads, %0d hit checks, %0d fills, %0d unused ops",
             op_count[OP_READ], op_count[OP_HIT], op_count[OP_FILL], op_count[OP_NOP]);
    $display("checked %0d results (%0d hits) under three sender idle rates",
             result_count, hit_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
